// ----- hdl/pelm_pkg.sv -----
`default_nettype none

package pelm_pkg;

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_BYTE = 2'd1;
    localparam logic [1:0] OP_EOL  = 2'd2;

    localparam logic [1:0] KIND_LITERAL = 2'd0;
    localparam logic [1:0] KIND_ANY     = 2'd1;
    localparam logic [1:0] KIND_RANGE   = 2'd2;

    localparam logic REG_ELEM_COUNT  = 1'b0;
    localparam logic REG_STRICT_MODE = 1'b1;

    localparam int PLEN_W = 5;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] lo;
        logic [7:0] hi;
    } elem_t;

    function automatic logic elem_hit(input elem_t e, input logic [7:0] b);
        logic hit;
        begin
            case (e.kind)
                KIND_LITERAL: hit = (b == e.lo);
                KIND_ANY:     hit = 1'b1;
                KIND_RANGE:   hit = (b >= e.lo) && (b <= e.hi);
                default:      hit = 1'b0;
            endcase
            return hit;
        end
    endfunction

endpackage

`default_nettype wire

// ----- hdl/pattern_element_line_matcher_top.sv -----
`default_nettype none

// Streaming line matcher for a compiled pattern of up to MAX_ELEMS elements (literal byte,
// any byte, or inclusive byte range), matched shift-and style with all element compares in
// parallel. Words with opcode 0 load one element, opcode 1 push one line byte, opcode 2 end
// the line and produce one result word (line_matched); opcode 3 is dropped. One word is taken
// every cycle unless intake stalls: a word is held in the input register while it is handled,
// and an end-of-line result is loaded from there into the output register. Only a result that
// is still waiting in the output register while the next end-of-line word reaches the work
// stage stalls intake. Registers over APB: elem_count at 0x0, strict_mode at 0x4; write them
// only while no line word is in flight.
module pattern_element_line_matcher_top
    import pelm_pkg::*;
#(
    parameter int MAX_ELEMS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,

    input  wire logic        item_valid,
    output logic             item_ready,
    input  wire logic [1:0]  opcode,
    input  wire logic [3:0]  elem_index,
    input  wire logic [1:0]  elem_kind,
    input  wire logic [7:0]  char_low,
    input  wire logic [7:0]  char_high,
    input  wire logic [7:0]  text_byte,

    output logic             result_valid,
    input  wire logic        result_ready,
    output logic             line_matched
);

    localparam int AW   = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;
    localparam int LCW0 = $clog2(MAX_ELEMS + 2);
    localparam int CW   = (LCW0 > PLEN_W) ? LCW0 : PLEN_W;
    localparam logic [CW-1:0] MAX_C  = CW'(MAX_ELEMS);
    localparam logic [CW-1:0] SAT_C  = CW'(MAX_ELEMS + 1);

    logic [PLEN_W-1:0]    elem_count_reg;
    logic                 strict_mode_reg;

    logic                 stage_valid_reg;
    logic [1:0]           stage_op_reg;
    logic [3:0]           stage_index_reg;
    elem_t                stage_elem_reg;
    logic [7:0]           stage_byte_reg;

    elem_t                element_table_reg [MAX_ELEMS];
    logic [MAX_ELEMS-1:0] active_reg;
    logic [MAX_ELEMS-1:0] active_next;
    logic                 seen_reg;
    logic                 seen_next;
    logic [CW-1:0]        line_count_reg;
    logic [CW-1:0]        line_count_next;

    logic                 result_valid_reg;
    logic                 line_matched_reg;

    logic                 cfg_write;
    logic                 stage_go;
    logic [CW-1:0]        len;
    logic [MAX_ELEMS-1:0] hits;
    logic [MAX_ELEMS-1:0] last_vec;
    logic                 start;
    logic                 eol_match;
    logic                 load_ok;

    // APB
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        case (paddr[2])
            REG_ELEM_COUNT:  prdata = 32'(elem_count_reg);
            REG_STRICT_MODE: prdata = 32'(strict_mode_reg);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elem_count_reg  <= '0;
            strict_mode_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_ELEM_COUNT:  elem_count_reg  <= pwdata[PLEN_W-1:0];
                REG_STRICT_MODE: strict_mode_reg <= pwdata[0];
                default:         ;
            endcase
        end
    end

    // Handshake
    assign stage_go   = stage_valid_reg &&
                        ((stage_op_reg != OP_EOL) || !result_valid_reg || result_ready);
    assign item_ready = !stage_valid_reg || stage_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            stage_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            stage_op_reg    <= opcode;
            stage_index_reg <= elem_index;
            stage_elem_reg  <= '{kind: elem_kind, lo: char_low, hi: char_high};
            stage_byte_reg  <= text_byte;
        end
    end

    // Element table
    assign load_ok = (32'(stage_index_reg) < 32'(MAX_ELEMS));

    always_ff @(posedge clk)
    begin
        if (stage_go && (stage_op_reg == OP_LOAD) && load_ok)
        begin
            element_table_reg[AW'(stage_index_reg)] <= stage_elem_reg;
        end
    end

    // Shift-and step
    assign len   = (CW'(elem_count_reg) > MAX_C) ? MAX_C : CW'(elem_count_reg);
    assign start = !strict_mode_reg || (line_count_reg == '0);

    always_comb
    begin
        for (int k = 0; k < MAX_ELEMS; k++)
        begin
            hits[k]     = (CW'(k) < len) && elem_hit(element_table_reg[k], stage_byte_reg);
            last_vec[k] = (CW'(k + 1) == len);
        end
    end

    always_comb
    begin
        active_next     = MAX_ELEMS'({active_reg, start}) & hits;
        seen_next       = seen_reg || (|(active_next & last_vec));
        line_count_next = (line_count_reg < SAT_C) ? line_count_reg + CW'(1) : line_count_reg;
        if (len == '0)
        begin
            eol_match = !strict_mode_reg || (line_count_reg == '0);
        end
        else if (strict_mode_reg)
        begin
            eol_match = (line_count_reg == len) && (|(active_reg & last_vec));
        end
        else
        begin
            eol_match = seen_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= '0;
            seen_reg       <= 1'b0;
            line_count_reg <= '0;
        end
        else if (stage_go)
        begin
            case (stage_op_reg)
                OP_BYTE:
                begin
                    active_reg     <= active_next;
                    seen_reg       <= seen_next;
                    line_count_reg <= line_count_next;
                end
                OP_EOL:
                begin
                    active_reg     <= '0;
                    seen_reg       <= 1'b0;
                    line_count_reg <= '0;
                end
                default: ;
            endcase
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (stage_go && (stage_op_reg == OP_EOL))
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_go && (stage_op_reg == OP_EOL))
        begin
            line_matched_reg <= eol_match;
        end
    end

    assign result_valid = result_valid_reg;
    assign line_matched = line_matched_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        line_count_reg <= SAT_C)
        else $error("line count past saturation");

    a_eol_clears: assert property (@(posedge clk) disable iff (!rst_n)
        stage_go && (stage_op_reg == OP_EOL) |=>
            (active_reg == '0) && !seen_reg && (line_count_reg == '0) && result_valid)
        else $error("end of line did not clear state or post result");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(stage_go && (stage_op_reg == OP_EOL)))
        else $error("result without end of line");

    a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready && stage_valid_reg && (stage_op_reg == OP_EOL)
            |-> !item_ready)
        else $error("intake open while result blocked");
`endif

endmodule

`default_nettype wire
